>>> hw/rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer: item structs, field
// widths, action and mode codes, intensity levels.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_BITS = 10;
	localparam int PIX_BITS   = 11;
	localparam int LEVEL_BITS = 8;
	localparam int ERR_BITS   = 12;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;

	localparam logic MODE_BRES = 1'b0;
	localparam logic MODE_WU   = 1'b1;

	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 8'd255;
	localparam logic [LEVEL_BITS-1:0] LEVEL_HALF = 8'd128;
	localparam logic [LEVEL_BITS-1:0] LEVEL_NONE = 8'd0;

	typedef struct packed {
		logic                  action;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
	} in_item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]   pixel_x;
		logic [PIX_BITS-1:0]   pixel_y;
		logic [LEVEL_BITS-1:0] intensity;
		logic                  valid_res;
		logic                  last;
	} out_item_t;

endpackage

>>> hw/rtl/lr_divider.sv
// ----------------------------------------------------------------------------
// lr_divider
// Restoring divider, one quotient bit per cycle. Computes
// floor(dividend * 2^(QUO_BITS-1) / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module lr_divider
	import lr_pkg::*;
#(
	parameter int QUO_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-1:0] dividend,
	input  logic [COORD_BITS-1:0] divisor,
	output logic                  done,
	output logic [QUO_BITS-1:0]   quotient
);

	localparam int CW = $clog2(QUO_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [COORD_BITS:0]   rem_q;
	logic [COORD_BITS-1:0] dvs_q;
	logic [QUO_BITS-1:0]   quo_q;

	logic                  ge;
	logic [COORD_BITS:0]   diff;

	// remainder stays below twice the divisor, so one compare per bit
	assign ge   = rem_q >= {1'b0, dvs_q};
	assign diff = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QUO_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {diff[COORD_BITS-1:0], 1'b0};
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < {dvs_q, 1'b0}))
		else $error("divider remainder out of range");

endmodule

>>> hw/rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Pull-driven line rasterizer: Bresenham or Xiaolin Wu anti-aliased lines.
//
// A start item (action 0) loads two endpoints and returns the first pixel;
// each next item (action 1) returns one more pixel, with the last flag on the
// final one, and a next item outside a line returns an all-zero result.
// algorithm_mode picks Bresenham (0) or Wu (1) and is sampled at each start.
// Next items and Bresenham starts go straight to the output register, so with
// the result taken at once a new item is accepted every cycle. A Wu start
// computes the gradient on the restoring divider, one quotient bit per cycle,
// and the input stalls until the first pixel is registered; a single-point line
// (zero length along the major axis) skips the division.
// ----------------------------------------------------------------------------
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int QUO_BITS = FRAC_BITS + 1;
	localparam int GW       = FRAC_BITS + 2;
	localparam int IW       = PIX_BITS + FRAC_BITS + 1;
	localparam int MW       = FRAC_BITS + 9;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_START_HI = 3'd1;
	localparam logic [2:0] PH_END_LO   = 3'd2;
	localparam logic [2:0] PH_END_HI   = 3'd3;
	localparam logic [2:0] PH_MID_LO   = 3'd4;
	localparam logic [2:0] PH_MID_HI   = 3'd5;

	localparam logic signed [GW-1:0] GRAD_ONE = GW'(1) << FRAC_BITS;
	localparam logic [MW-1:0]        LVL_RND  = MW'(1) << (FRAC_BITS - 1);

	// control
	logic [1:0] state_q;
	logic       algorithm_mode_q;
	logic       line_mode_q;
	logic       line_active_q;
	logic [2:0] wu_phase_q;

	// line state
	logic [PIX_BITS-1:0]        cursor_x_q, cursor_y_q, target_x_q, target_y_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COORD_BITS-1:0]      mag_dx_q, mag_dy_q;
	logic [1:0]                 step_signs_q;
	logic                       steep_q;
	logic                       dy_neg_q;
	logic                       dx_zero_q;
	logic signed [GW-1:0]       gradient_q;
	logic signed [IW-1:0]       intercept_q;
	out_item_t                  out_q;

	logic acc, is_start, start_wu, next_ok, out_take, div_fin;

	// endpoint setup
	logic [COORD_BITS-1:0] adx, ady;
	logic                  w_steep, w_swap, w_neg;
	logic [COORD_BITS-1:0] a_u1, a_v1, a_u2, a_v2;
	logic [COORD_BITS-1:0] u1, v1, u2, v2, wdx, wady;

	// divider
	logic                div_start, div_done;
	logic [QUO_BITS-1:0] div_q;
	logic signed [GW-1:0] grad_new, grad_q_ext;
	logic signed [IW-1:0] icpt_new;

	// Bresenham step
	logic signed [ERR_BITS:0] e2, dx_ext, dy_ext, err_sum;
	logic                     cx, cy, bres_done, bres_single;
	logic [PIX_BITS-1:0]      bx, by;

	// Wu step
	logic [IW-1:0]         iy;
	logic [PIX_BITS-1:0]   fl;
	logic [FRAC_BITS-1:0]  fr;
	logic [FRAC_BITS:0]    weight;
	logic [MW-1:0]         lvl_sum;
	logic [LEVEL_BITS-1:0] lvl;
	logic                  done_end, done_mid;
	logic [PIX_BITS-1:0]   pu, pv;
	logic [LEVEL_BITS-1:0] plvl;
	logic                  plast;

	out_item_t res, wu_first;

	// ---------------- handshakes
	assign out_take  = (state_q == S_OUT) && !out_stall;
	assign in_stall  = !((state_q == S_IDLE) || out_take);
	assign acc       = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

	assign is_start = (in_item.action == ACT_START);
	assign start_wu = is_start && (algorithm_mode_q == MODE_WU);
	assign next_ok  = acc && (in_item.action == ACT_NEXT) && line_active_q;

	// ---------------- endpoint setup
	assign adx = (in_item.x_end >= in_item.x_start) ? (in_item.x_end - in_item.x_start)
		: (in_item.x_start - in_item.x_end);
	assign ady = (in_item.y_end >= in_item.y_start) ? (in_item.y_end - in_item.y_start)
		: (in_item.y_start - in_item.y_end);

	assign w_steep = ady > adx;
	assign a_u1 = w_steep ? in_item.y_start : in_item.x_start;
	assign a_v1 = w_steep ? in_item.x_start : in_item.y_start;
	assign a_u2 = w_steep ? in_item.y_end   : in_item.x_end;
	assign a_v2 = w_steep ? in_item.x_end   : in_item.y_end;
	assign w_swap = a_u1 > a_u2;
	assign u1 = w_swap ? a_u2 : a_u1;
	assign v1 = w_swap ? a_v2 : a_v1;
	assign u2 = w_swap ? a_u1 : a_u2;
	assign v2 = w_swap ? a_v1 : a_v2;
	assign wdx  = u2 - u1;
	assign w_neg = v2 < v1;
	assign wady = w_neg ? (v1 - v2) : (v2 - v1);

	assign bres_single = (in_item.x_start == in_item.x_end)
		&& (in_item.y_start == in_item.y_end);

	// ---------------- gradient
	assign div_start = acc && start_wu && (wdx != '0);
	assign div_fin   = (state_q == S_DIV) && (dx_zero_q || div_done);

	lr_divider #(
		.QUO_BITS(QUO_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wady),
		.divisor  (wdx),
		.done     (div_done),
		.quotient (div_q)
	);

	assign grad_q_ext = $signed({1'b0, div_q});
	assign grad_new   = dx_zero_q ? GRAD_ONE : (dy_neg_q ? -grad_q_ext : grad_q_ext);
	assign icpt_new   = $signed({1'b0, cursor_y_q, {FRAC_BITS{1'b0}}})
		+ $signed({{(IW-GW){grad_new[GW-1]}}, grad_new});

	always_comb begin
		wu_first           = '0;
		wu_first.pixel_x   = steep_q ? cursor_y_q : cursor_x_q;
		wu_first.pixel_y   = steep_q ? cursor_x_q : cursor_y_q;
		wu_first.intensity = LEVEL_HALF;
		wu_first.valid_res = 1'b1;
	end

	// ---------------- Bresenham step
	assign e2      = {err_q, 1'b0};
	assign dx_ext  = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, mag_dx_q});
	assign dy_ext  = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, mag_dy_q});
	assign cx      = e2 >= -dy_ext;
	assign cy      = e2 <= dx_ext;
	assign err_sum = {err_q[ERR_BITS-1], err_q} - (cx ? dy_ext : '0) + (cy ? dx_ext : '0);
	assign bx = !cx ? cursor_x_q
		: (step_signs_q[0] ? cursor_x_q - PIX_BITS'(1) : cursor_x_q + PIX_BITS'(1));
	assign by = !cy ? cursor_y_q
		: (step_signs_q[1] ? cursor_y_q - PIX_BITS'(1) : cursor_y_q + PIX_BITS'(1));
	assign bres_done = (bx == target_x_q) && (by == target_y_q);

	// ---------------- Wu step
	assign iy = intercept_q[IW-1] ? '0 : intercept_q;
	assign fl = iy[FRAC_BITS +: PIX_BITS];
	assign fr = iy[FRAC_BITS-1:0];
	assign weight = (wu_phase_q == PH_MID_HI) ? {1'b0, fr}
		: ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fr});
	// 255 * w rounded, as (w << 8) - w
	assign lvl_sum = {weight, 8'b0} - {8'b0, weight} + LVL_RND;
	assign lvl = lvl_sum[FRAC_BITS+8] ? LEVEL_FULL : lvl_sum[FRAC_BITS +: LEVEL_BITS];

	assign done_end = {1'b0, target_x_q} < ({1'b0, cursor_x_q} + (PIX_BITS+1)'(2));
	assign done_mid = ({1'b0, cursor_x_q} + (PIX_BITS+1)'(1)) >= {1'b0, target_x_q};

	always_comb begin
		pu    = cursor_x_q;
		pv    = fl;
		plvl  = lvl;
		plast = 1'b0;
		case (wu_phase_q)
			PH_START_HI: begin
				pv   = cursor_y_q + PIX_BITS'(1);
				plvl = LEVEL_NONE;
			end
			PH_END_LO: begin
				pu   = target_x_q;
				pv   = target_y_q;
				plvl = LEVEL_HALF;
			end
			PH_END_HI: begin
				pu    = target_x_q;
				pv    = target_y_q + PIX_BITS'(1);
				plvl  = LEVEL_NONE;
				plast = done_end;
			end
			PH_MID_HI: begin
				pv    = fl + PIX_BITS'(1);
				plast = done_mid;
			end
			default: begin
			end
		endcase
	end

	// ---------------- result of an accepted item
	always_comb begin
		res = '0;
		if (is_start) begin
			res.pixel_x   = {1'b0, in_item.x_start};
			res.pixel_y   = {1'b0, in_item.y_start};
			res.intensity = LEVEL_FULL;
			res.valid_res = 1'b1;
			res.last      = bres_single;
		end else if (!line_active_q) begin
			res = '0;
		end else if (line_mode_q == MODE_BRES) begin
			res.pixel_x   = bx;
			res.pixel_y   = by;
			res.intensity = LEVEL_FULL;
			res.valid_res = 1'b1;
			res.last      = bres_done;
		end else begin
			res.pixel_x   = steep_q ? pv : pu;
			res.pixel_y   = steep_q ? pu : pv;
			res.intensity = plvl;
			res.valid_res = 1'b1;
			res.last      = plast;
		end
	end

	// ---------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			algorithm_mode_q <= MODE_BRES;
			line_mode_q      <= MODE_BRES;
			line_active_q    <= 1'b0;
			wu_phase_q       <= PH_IDLE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				algorithm_mode_q <= cfg_data;
			end

			case (state_q)
				S_IDLE, S_OUT: begin
					if (acc) begin
						state_q <= start_wu ? S_DIV : S_OUT;
					end else if (out_take) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_fin) begin
						state_q <= S_OUT;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (acc && is_start) begin
				line_mode_q <= algorithm_mode_q;
				if (algorithm_mode_q == MODE_WU) begin
					line_active_q <= 1'b1;
					wu_phase_q    <= PH_START_HI;
				end else begin
					line_active_q <= !bres_single;
				end
			end else if (next_ok) begin
				if (line_mode_q == MODE_BRES) begin
					if (bres_done) begin
						line_active_q <= 1'b0;
					end
				end else begin
					case (wu_phase_q)
						PH_START_HI: wu_phase_q <= PH_END_LO;
						PH_END_LO:   wu_phase_q <= PH_END_HI;
						PH_END_HI: begin
							wu_phase_q <= PH_MID_LO;
							if (done_end) begin
								line_active_q <= 1'b0;
							end
						end
						PH_MID_HI: begin
							wu_phase_q <= PH_MID_LO;
							if (done_mid) begin
								line_active_q <= 1'b0;
							end
						end
						default: wu_phase_q <= PH_MID_HI;
					endcase
				end
			end
		end
	end

	// ---------------- datapath
	always_ff @(posedge clk) begin
		if (acc && is_start) begin
			if (algorithm_mode_q == MODE_WU) begin
				cursor_x_q <= {1'b0, u1};
				cursor_y_q <= {1'b0, v1};
				target_x_q <= {1'b0, u2};
				target_y_q <= {1'b0, v2};
				steep_q    <= w_steep;
				dy_neg_q   <= w_neg;
				dx_zero_q  <= (wdx == '0);
			end else begin
				cursor_x_q   <= {1'b0, in_item.x_start};
				cursor_y_q   <= {1'b0, in_item.y_start};
				target_x_q   <= {1'b0, in_item.x_end};
				target_y_q   <= {1'b0, in_item.y_end};
				mag_dx_q     <= adx;
				mag_dy_q     <= ady;
				step_signs_q <= {!(in_item.y_start < in_item.y_end),
					!(in_item.x_start < in_item.x_end)};
				err_q        <= $signed({2'b0, adx}) - $signed({2'b0, ady});
				steep_q      <= 1'b0;
			end
		end else if (next_ok) begin
			if (line_mode_q == MODE_BRES) begin
				cursor_x_q <= bx;
				cursor_y_q <= by;
				err_q      <= err_sum[ERR_BITS-1:0];
			end else if (wu_phase_q == PH_END_HI) begin
				cursor_x_q <= cursor_x_q + PIX_BITS'(1);
			end else if (wu_phase_q == PH_MID_HI) begin
				cursor_x_q  <= cursor_x_q + PIX_BITS'(1);
				intercept_q <= intercept_q + $signed({{(IW-GW){gradient_q[GW-1]}}, gradient_q});
			end
		end

		if (div_fin) begin
			gradient_q  <= grad_new;
			intercept_q <= icpt_new;
		end

		if (acc && !start_wu) begin
			out_q <= res;
		end else if (div_fin) begin
			out_q <= wu_first;
		end
	end

	a_div_only_wu: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (line_mode_q == MODE_WU && line_active_q))
		else $error("gradient division outside a Wu line");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_q.last) |-> !line_active_q)
		else $error("line still active after its last pixel");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		div_fin |=> (out_valid && out_q.valid_res && !out_q.last))
		else $error("Wu start did not present its first pixel");

	a_wu_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(line_active_q && line_mode_q == MODE_WU)
			|-> (wu_phase_q >= PH_START_HI && wu_phase_q <= PH_MID_HI))
		else $error("Wu phase out of range on an active line");

endmodule
